// File: hdl/twht_pkg.sv
// Package for the topmost window hit test block: request and response
// structs, action codes and parameter defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twht_pkg;

  // Field widths of the request and response payloads
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned INDEX_W  = 8;

  // Parameter defaults for the top level
  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned COORD_BITS_DEF  = 16;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [FIELD_W-1:0] left_edge;
    logic signed [FIELD_W-1:0] bottom_edge;
    logic signed [FIELD_W-1:0] right_edge;
    logic signed [FIELD_W-1:0] top_edge;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] entry_index;
    logic               refused;
  } rsp_t;

endpackage : twht_pkg

`default_nettype wire

// File: hdl/twht_rect_mem.sv
// Rectangle table storage: one write port, one read port with registered
// read data. Generic; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module twht_rect_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write the new rectangle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : twht_rect_mem

`default_nettype wire

// File: hdl/topmost_window_hit_test.sv
// Topmost window hit test: top level with control sequencer and response
// register. Depends on twht_pkg and twht_rect_mem.
//
// Usage: a request on in_data_i (valid/stall) carries an action. An insert
// appends a rectangle with inclusive edges and returns the assigned index,
// or refused when the table holds MAX_ENTRIES. A query returns the index of
// the newest rectangle that contains the point, or a miss. A clear empties
// the table. Every request gives exactly one response on out_data_o.
// Insert, clear, unused codes and a query on an empty table finish in the
// accept cycle; the response is visible in the cycle after. Any other query
// scans the table from the newest entry down, one memory read per cycle;
// the table memory registers its read data, and the scan stops at the first
// entry that contains the point or after entry 0, holding the input channel
// off while it runs.
// A request is taken only while the sequencer is idle and the response
// register is empty or being drained, so a stalled response holds the next
// request off. Reset empties the table (count to zero) and drops any pending
// response; the memory contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module topmost_window_hit_test
  import twht_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_data_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned RECT_W = 4 * COORD_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  // Take the low COORD_BITS bits of a raw field
  function automatic logic [COORD_BITS-1:0] to_coord(input logic [FIELD_W-1:0] f);
    logic [31:0] ext;
    ext = 32'(f);
    return ext[COORD_BITS-1:0];
  endfunction

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      addr_q, addr_d;
  logic                  issue_q, issue_d;
  logic                  chk_q, chk_d;
  logic [IDX_W-1:0]      chk_idx_q, chk_idx_d;
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  rsp_t                  res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_data_q, out_data_d;

  logic                  out_free;
  logic                  accept;
  logic                  full;
  logic [CNT_W-1:0]      cnt_m1;
  logic [31:0]           cnt_ext;
  logic [31:0]           chk_ext;
  logic                  wr_en;
  logic [RECT_W-1:0]     wr_data;
  logic                  rd_en;
  logic [RECT_W-1:0]     rd_data;
  logic                  match;
  logic                  load_out;
  rsp_t                  new_rsp;

  logic signed [COORD_BITS-1:0] r_left, r_bottom, r_right, r_top, p_x, p_y;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(MAX_ENTRIES));
  assign cnt_m1     = count_q - CNT_W'(1);
  assign cnt_ext    = 32'(count_q);
  assign chk_ext    = 32'(chk_idx_q);

  // Table memory
  assign wr_en   = accept && (in_data_i.action == ACT_INSERT) && !full;
  assign wr_data = {to_coord(in_data_i.left_edge), to_coord(in_data_i.bottom_edge),
                    to_coord(in_data_i.right_edge), to_coord(in_data_i.top_edge)};
  assign rd_en   = (state_q == ST_SCAN) && issue_q;

  twht_rect_mem #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (RECT_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data)
  );

  // Containment check on the entry read last cycle
  assign r_left   = rd_data[4*COORD_BITS-1:3*COORD_BITS];
  assign r_bottom = rd_data[3*COORD_BITS-1:2*COORD_BITS];
  assign r_right  = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign r_top    = rd_data[COORD_BITS-1:0];
  assign p_x      = px_q;
  assign p_y      = py_q;
  assign match    = (p_x >= r_left) && (p_x <= r_right) &&
                    (p_y >= r_bottom) && (p_y <= r_top);

  // Sequence requests and the table scan
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    addr_d    = addr_q;
    issue_d   = issue_q;
    chk_d     = chk_q;
    chk_idx_d = chk_idx_q;
    px_d      = px_q;
    py_d      = py_q;
    res_d     = res_q;
    load_out  = 1'b0;
    new_rsp   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.action)
            ACT_INSERT: begin
              load_out = 1'b1;
              if (full) begin
                new_rsp.refused = 1'b1;
              end else begin
                new_rsp.entry_index = cnt_ext[INDEX_W-1:0];
                count_d             = count_q + CNT_W'(1);
              end
            end
            ACT_QUERY: begin
              px_d = to_coord(in_data_i.point_x);
              py_d = to_coord(in_data_i.point_y);
              if (count_q == '0) begin
                load_out = 1'b1;
              end else begin
                addr_d  = cnt_m1[IDX_W-1:0];
                issue_d = 1'b1;
                chk_d   = 1'b0;
                state_d = ST_SCAN;
              end
            end
            ACT_CLEAR: begin
              load_out = 1'b1;
              count_d  = '0;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // advance the read address toward entry 0
        chk_d     = issue_q;
        chk_idx_d = addr_q;
        if (issue_q) begin
          if (addr_q == '0) begin
            issue_d = 1'b0;
          end else begin
            addr_d = addr_q - IDX_W'(1);
          end
        end
        // finish on the topmost hit or after entry 0
        if (chk_q && (match || (chk_idx_q == '0))) begin
          new_rsp.hit = match;
          if (match) begin
            new_rsp.entry_index = chk_ext[INDEX_W-1:0];
          end
          issue_d = 1'b0;
          chk_d   = 1'b0;
          if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            res_d   = new_rsp;
            state_d = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        // hold the query result until the response register frees up
        new_rsp = res_q;
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Response register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = new_rsp;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    chk_idx_q  <= chk_idx_d;
    px_q       <= px_d;
    py_q       <= py_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks on the sequencer
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("request taken while a query is in flight");

  a_scan_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (issue_q || chk_q))
    else $error("scan with nothing to read or check");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.action == ACT_INSERT) && !full)
      |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not advance the entry count");

endmodule : topmost_window_hit_test

`default_nettype wire
